// ----- src/i2c_mbe_pkg.sv -----
package i2c_mbe_pkg;

  // Input kind codes as they arrive on the input channel.
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_WRITE = 3'd2;
  localparam logic [2:0] KIND_READ  = 3'd3;
  localparam logic [2:0] KIND_STOP  = 3'd4;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [2:0] REG_LOW_TICKS        = 3'd0;
  localparam logic [2:0] REG_HIGH_TICKS       = 3'd1;
  localparam logic [2:0] REG_BUS_FREE_TICKS   = 3'd2;
  localparam logic [2:0] REG_START_HOLD_TICKS = 3'd3;
  localparam logic [2:0] REG_STOP_SETUP_TICKS = 3'd4;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TICK_W     = 16;

  // Depth of the queue between the front and the back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       sda_in;
    logic       scl_in;
  } entry_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic       ack_bit;
    logic [7:0] read_byte;
  } result_t;

  typedef struct packed {
    logic [TICK_W-1:0] low_ticks;
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W-1:0] bus_free_ticks;
    logic [TICK_W-1:0] start_hold_ticks;
    logic [TICK_W-1:0] stop_setup_ticks;
  } cfg_t;

  typedef enum logic [18:0] {
    PH_IDLE    = 19'h00001,
    PH_ST_WAIT = 19'h00002,
    PH_ST_BUF  = 19'h00004,
    PH_ST_HOLD = 19'h00008,
    PH_W_LOW   = 19'h00010,
    PH_W_RISE  = 19'h00020,
    PH_W_HIGH  = 19'h00040,
    PH_WA_LOW  = 19'h00080,
    PH_WA_RISE = 19'h00100,
    PH_WA_HIGH = 19'h00200,
    PH_R_LOW   = 19'h00400,
    PH_R_RISE  = 19'h00800,
    PH_R_HIGH  = 19'h01000,
    PH_RA_LOW  = 19'h02000,
    PH_RA_RISE = 19'h04000,
    PH_RA_HIGH = 19'h08000,
    PH_P_LOW   = 19'h10000,
    PH_P_RISE  = 19'h20000,
    PH_P_SETUP = 19'h40000
  } phase_t;

  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

// ----- src/i2c_mbe_if.sv -----
interface i2c_mbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       sda_in;
  logic       scl_in;

  modport source (output valid, kind, data_byte, last_byte, sda_in, scl_in, input ready);
  modport sink   (input valid, kind, data_byte, last_byte, sda_in, scl_in, output ready);
endinterface

interface i2c_mbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_pull_low;
  logic       sda_pull_low;
  logic       busy_res;
  logic       done_res;
  logic       ack_bit;
  logic [7:0] read_byte;

  modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res, ack_bit,
                  read_byte, input ready);
  modport sink   (input valid, scl_pull_low, sda_pull_low, busy_res, done_res, ack_bit,
                  read_byte, output ready);
endinterface

// ----- src/i2c_master_byte_engine_top.sv -----
// Channel   Direction  Word                                   Handshake
// in_ch     in         kind, data_byte, last_byte, pins       valid/ready
// out_ch    out        pull_low pair, busy, done, ack, byte   valid/ready
// psel...   in/out     five 16-bit tick registers at 4*i      APB, pready high
//
// One input word is one bus tick; a word can be taken every cycle while the queue is not full.
// Each word gives one result word; it is registered first in the two-entry queue,
// then in the result register behind the bus state machine.
// A stalled result holds the state machine; the queue keeps taking words until full.
// Synchronous active-low reset clears the queue, the state machine and the registers.
module i2c_master_byte_engine_top
  import i2c_mbe_pkg::*;
#(
  parameter int DELAY_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  i2c_mbe_in_if.sink            in_ch,
  i2c_mbe_out_if.source         out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg_r;
  logic    cfg_wr;
  logic    push_valid, push_ready;
  entry_t  push_entry;
  logic    pop_valid, pop_ready;
  entry_t  pop_entry;
  result_t out_word;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_LOW_TICKS:        cfg_r.low_ticks        <= pwdata[TICK_W-1:0];
        REG_HIGH_TICKS:       cfg_r.high_ticks       <= pwdata[TICK_W-1:0];
        REG_BUS_FREE_TICKS:   cfg_r.bus_free_ticks   <= pwdata[TICK_W-1:0];
        REG_START_HOLD_TICKS: cfg_r.start_hold_ticks <= pwdata[TICK_W-1:0];
        REG_STOP_SETUP_TICKS: cfg_r.stop_setup_ticks <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_LOW_TICKS:        prdata = CFG_DATA_W'(cfg_r.low_ticks);
      REG_HIGH_TICKS:       prdata = CFG_DATA_W'(cfg_r.high_ticks);
      REG_BUS_FREE_TICKS:   prdata = CFG_DATA_W'(cfg_r.bus_free_ticks);
      REG_START_HOLD_TICKS: prdata = CFG_DATA_W'(cfg_r.start_hold_ticks);
      REG_STOP_SETUP_TICKS: prdata = CFG_DATA_W'(cfg_r.stop_setup_ticks);
      default:              prdata = '0;
    endcase
  end

  i2c_mbe_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  i2c_mbe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  i2c_mbe_back #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word)
  );

  assign out_ch.scl_pull_low = out_word.scl_pull_low;
  assign out_ch.sda_pull_low = out_word.sda_pull_low;
  assign out_ch.busy_res     = out_word.busy_res;
  assign out_ch.done_res     = out_word.done_res;
  assign out_ch.ack_bit      = out_word.ack_bit;
  assign out_ch.read_byte    = out_word.read_byte;

`ifndef NO_ASSERTIONS
  // An operation that has just finished leaves the engine idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.done_res |-> !out_ch.busy_res)
    else $error("done word reports busy");

  // The queue refuses input only when it holds words for the back.
  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> pop_valid)
    else $error("input stalled with an empty queue");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid straight after reset");
`endif

endmodule

// ----- src/i2c_mbe_front.sv -----
module i2c_mbe_front
  import i2c_mbe_pkg::*;
(
  i2c_mbe_in_if.sink in_ch,
  output logic       push_valid,
  input  logic       push_ready,
  output entry_t     push_entry
);

  cmd_t cmd;

  // Undefined kinds are treated as a plain tick.
  always_comb begin
    unique case (in_ch.kind)
      KIND_START: cmd = CMD_START;
      KIND_WRITE: cmd = CMD_WRITE;
      KIND_READ:  cmd = CMD_READ;
      KIND_STOP:  cmd = CMD_STOP;
      default:    cmd = CMD_NONE;
    endcase
  end

  assign push_valid           = in_ch.valid;
  assign in_ch.ready          = push_ready;
  assign push_entry.cmd       = cmd;
  assign push_entry.data_byte = in_ch.data_byte;
  assign push_entry.last_byte = in_ch.last_byte;
  assign push_entry.sda_in    = in_ch.sda_in;
  assign push_entry.scl_in    = in_ch.scl_in;

endmodule

// ----- src/i2c_mbe_queue.sv -----
module i2c_mbe_queue
  import i2c_mbe_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_entry
);

  entry_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- src/i2c_mbe_back.sv -----
module i2c_mbe_back
  import i2c_mbe_pkg::*;
#(
  parameter int DELAY_WIDTH = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    pop_valid,
  output logic    pop_ready,
  input  entry_t  pop_entry,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_word
);

  localparam int ExtW = (DELAY_WIDTH > TICK_W) ? DELAY_WIDTH : TICK_W;

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             bit_cnt_r, bit_cnt_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [DELAY_WIDTH-1:0] delay_r, delay_nxt;
  logic                   nack_r, nack_nxt;
  logic                   ack_r, ack_nxt;
  logic                   scl_r, scl_nxt;
  logic                   sda_r, sda_nxt;
  logic [7:0]             hold_r, hold_nxt;
  logic                   done;
  logic                   over;
  logic                   advance;
  logic                   out_valid_r;
  result_t                out_word_r;

  function automatic logic [DELAY_WIDTH-1:0] load_ticks(input logic [TICK_W-1:0] t);
    logic [ExtW-1:0] e;
    e = ExtW'(t);
    return e[DELAY_WIDTH-1:0];
  endfunction

  // The back steps once per word, and only when the result register is free.
  assign advance   = pop_valid && (!out_valid_r || out_ready);
  assign pop_ready = !out_valid_r || out_ready;
  assign over      = (delay_r == '0);

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    delay_nxt   = over ? delay_r : delay_r - 1'b1;
    nack_nxt    = nack_r;
    ack_nxt     = ack_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    hold_nxt    = hold_r;
    done        = 1'b0;

    unique case (phase_r)
      PH_IDLE: begin
        delay_nxt = delay_r;
        unique case (pop_entry.cmd)
          CMD_START: begin
            scl_nxt     = 1'b0;
            sda_nxt     = 1'b0;
            shift_nxt   = pop_entry.data_byte;
            bit_cnt_nxt = '0;
            phase_nxt   = PH_ST_WAIT;
          end
          CMD_WRITE: begin
            shift_nxt   = pop_entry.data_byte;
            bit_cnt_nxt = '0;
            scl_nxt     = 1'b1;
            sda_nxt     = (pop_entry.data_byte & MSB_MASK) == '0;
            delay_nxt   = load_ticks(cfg.low_ticks);
            phase_nxt   = PH_W_LOW;
          end
          CMD_READ: begin
            nack_nxt    = pop_entry.last_byte;
            shift_nxt   = '0;
            bit_cnt_nxt = '0;
            scl_nxt     = 1'b1;
            sda_nxt     = 1'b0;
            delay_nxt   = load_ticks(cfg.low_ticks);
            phase_nxt   = PH_R_LOW;
          end
          CMD_STOP: begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
            delay_nxt = load_ticks(cfg.low_ticks);
            phase_nxt = PH_P_LOW;
          end
          default: ;
        endcase
      end
      PH_ST_WAIT: begin
        delay_nxt = delay_r;
        if (pop_entry.sda_in && pop_entry.scl_in) begin
          delay_nxt = load_ticks(cfg.bus_free_ticks);
          phase_nxt = PH_ST_BUF;
        end
      end
      PH_ST_BUF: begin
        if (over) begin
          sda_nxt   = 1'b1;
          delay_nxt = load_ticks(cfg.start_hold_ticks);
          phase_nxt = PH_ST_HOLD;
        end
      end
      PH_ST_HOLD: begin
        if (over) begin
          scl_nxt   = 1'b1;
          sda_nxt   = (shift_r & MSB_MASK) == '0;
          delay_nxt = load_ticks(cfg.low_ticks);
          phase_nxt = PH_W_LOW;
        end
      end
      PH_W_LOW: begin
        if (over) begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_W_RISE;
        end
      end
      PH_W_RISE: begin
        delay_nxt = delay_r;
        if (pop_entry.scl_in) begin
          delay_nxt = load_ticks(cfg.high_ticks);
          phase_nxt = PH_W_HIGH;
        end
      end
      PH_W_HIGH: begin
        if (over) begin
          shift_nxt   = {shift_r[6:0], 1'b0};
          bit_cnt_nxt = bit_cnt_r + 1'b1;
          scl_nxt     = 1'b1;
          delay_nxt   = load_ticks(cfg.low_ticks);
          if (bit_cnt_nxt >= BITS_PER_BYTE) begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_WA_LOW;
          end else begin
            sda_nxt   = (shift_nxt & MSB_MASK) == '0;
            phase_nxt = PH_W_LOW;
          end
        end
      end
      PH_WA_LOW: begin
        if (over) begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_WA_RISE;
        end
      end
      PH_WA_RISE: begin
        delay_nxt = delay_r;
        if (pop_entry.scl_in) begin
          ack_nxt   = pop_entry.sda_in;
          delay_nxt = load_ticks(cfg.high_ticks);
          phase_nxt = PH_WA_HIGH;
        end
      end
      PH_WA_HIGH: begin
        if (over) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
      end
      PH_R_LOW: begin
        if (over) begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_R_RISE;
        end
      end
      PH_R_RISE: begin
        delay_nxt = delay_r;
        if (pop_entry.scl_in) begin
          shift_nxt = {shift_r[6:0], pop_entry.sda_in};
          delay_nxt = load_ticks(cfg.high_ticks);
          phase_nxt = PH_R_HIGH;
        end
      end
      PH_R_HIGH: begin
        if (over) begin
          bit_cnt_nxt = bit_cnt_r + 1'b1;
          scl_nxt     = 1'b1;
          delay_nxt   = load_ticks(cfg.low_ticks);
          if (bit_cnt_nxt >= BITS_PER_BYTE) begin
            hold_nxt  = shift_r;
            sda_nxt   = !nack_r;
            phase_nxt = PH_RA_LOW;
          end else begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_R_LOW;
          end
        end
      end
      PH_RA_LOW: begin
        if (over) begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_RA_RISE;
        end
      end
      PH_RA_RISE: begin
        delay_nxt = delay_r;
        if (pop_entry.scl_in) begin
          delay_nxt = load_ticks(cfg.high_ticks);
          phase_nxt = PH_RA_HIGH;
        end
      end
      PH_RA_HIGH: begin
        if (over) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
      end
      PH_P_LOW: begin
        if (over) begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_P_RISE;
        end
      end
      PH_P_RISE: begin
        delay_nxt = delay_r;
        if (pop_entry.scl_in) begin
          delay_nxt = load_ticks(cfg.stop_setup_ticks);
          phase_nxt = PH_P_SETUP;
        end
      end
      PH_P_SETUP: begin
        if (over) begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
      end
      default: begin
        delay_nxt = delay_r;
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      delay_r     <= '0;
      nack_r      <= 1'b0;
      ack_r       <= 1'b0;
      scl_r       <= 1'b0;
      sda_r       <= 1'b0;
      hold_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        phase_r   <= phase_nxt;
        bit_cnt_r <= bit_cnt_nxt;
        shift_r   <= shift_nxt;
        delay_r   <= delay_nxt;
        nack_r    <= nack_nxt;
        ack_r     <= ack_nxt;
        scl_r     <= scl_nxt;
        sda_r     <= sda_nxt;
        hold_r    <= hold_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r.scl_pull_low <= scl_nxt;
      out_word_r.sda_pull_low <= sda_nxt;
      out_word_r.busy_res     <= (phase_nxt != PH_IDLE);
      out_word_r.done_res     <= done;
      out_word_r.ack_bit      <= ack_nxt;
      out_word_r.read_byte    <= hold_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- bench/i2c_master_byte_engine_top_test.sv -----
module i2c_master_byte_engine_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import i2c_mbe_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
    logic       sda;
    logic       scl;
  } bus_word_t;

  // Mirror of the engine: phase, bit counter, shifter, delay and line drives.
  typedef struct packed {
    phase_t            ph;
    logic [3:0]        nbits;
    logic [7:0]        shreg;
    logic [TICK_W-1:0] dly;
    logic              nack;
    logic              ack;
    logic              scl_dr;
    logic              sda_dr;
    logic [7:0]        rx_hold;
    logic              done;
  } engine_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  i2c_mbe_in_if  in_ch ();
  i2c_mbe_out_if out_ch ();

  i2c_master_byte_engine_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bus_word_t tick_q[$];
  result_t   due_status_q[$];
  engine_t   gen_s;
  engine_t   chk_s;
  cfg_t      cfg_m;
  int        n_pushed;
  int        n_taken;
  int        n_errors;
  int        in_gap;
  int        out_stall;
  int        stall_cycles;
  logic      tick_taken;
  logic      gaps_on;
  logic      gaps_allowed;

  function automatic engine_t drive_bit_out(engine_t s, cfg_t c);
    s.scl_dr = 1'b1;
    s.sda_dr = ((s.shreg & MSB_MASK) == '0);
    s.dly    = c.low_ticks;
    s.ph     = PH_W_LOW;
    return s;
  endfunction

  function automatic engine_t drive_bit_in(engine_t s, cfg_t c);
    s.scl_dr = 1'b1;
    s.sda_dr = 1'b0;
    s.dly    = c.low_ticks;
    s.ph     = PH_R_LOW;
    return s;
  endfunction

  // One bus tick of the engine.
  function automatic engine_t bus_tick(engine_t s, cfg_t c, bus_word_t w);
    logic expired;
    expired = (s.dly == '0);
    s.done  = 1'b0;
    // Every timed phase counts down unless its wait has run out this tick.
    case (s.ph)
      PH_ST_BUF, PH_ST_HOLD, PH_W_LOW, PH_W_HIGH, PH_WA_LOW, PH_WA_HIGH, PH_R_LOW,
      PH_R_HIGH, PH_RA_LOW, PH_RA_HIGH, PH_P_LOW, PH_P_SETUP: begin
        if (!expired) s.dly = s.dly - 1'b1;
      end
      default: ;
    endcase
    case (s.ph)
      PH_IDLE: begin
        case (w.kind)
          KIND_START: begin
            s.scl_dr = 1'b0;
            s.sda_dr = 1'b0;
            s.shreg  = w.data;
            s.nbits  = '0;
            s.ph     = PH_ST_WAIT;
          end
          KIND_WRITE: begin
            s.shreg = w.data;
            s.nbits = '0;
            s       = drive_bit_out(s, c);
          end
          KIND_READ: begin
            s.nack  = w.last;
            s.shreg = '0;
            s.nbits = '0;
            s       = drive_bit_in(s, c);
          end
          KIND_STOP: begin
            s.scl_dr = 1'b1;
            s.sda_dr = 1'b1;
            s.dly    = c.low_ticks;
            s.ph     = PH_P_LOW;
          end
          default: ;
        endcase
      end
      PH_ST_WAIT: begin
        if (w.sda && w.scl) begin
          s.dly = c.bus_free_ticks;
          s.ph  = PH_ST_BUF;
        end
      end
      PH_ST_BUF: begin
        if (expired) begin
          s.sda_dr = 1'b1;
          s.dly    = c.start_hold_ticks;
          s.ph     = PH_ST_HOLD;
        end
      end
      PH_ST_HOLD: if (expired) s = drive_bit_out(s, c);
      PH_W_LOW: begin
        if (expired) begin
          s.scl_dr = 1'b0;
          s.ph     = PH_W_RISE;
        end
      end
      PH_W_RISE: begin
        if (w.scl) begin
          s.dly = c.high_ticks;
          s.ph  = PH_W_HIGH;
        end
      end
      PH_W_HIGH: begin
        if (expired) begin
          s.shreg = {s.shreg[6:0], 1'b0};
          s.nbits = s.nbits + 1'b1;
          if (s.nbits >= BITS_PER_BYTE) begin
            s.scl_dr = 1'b1;
            s.sda_dr = 1'b0;
            s.dly    = c.low_ticks;
            s.ph     = PH_WA_LOW;
          end else begin
            s = drive_bit_out(s, c);
          end
        end
      end
      PH_WA_LOW: begin
        if (expired) begin
          s.scl_dr = 1'b0;
          s.ph     = PH_WA_RISE;
        end
      end
      PH_WA_RISE: begin
        if (w.scl) begin
          s.ack = w.sda;
          s.dly = c.high_ticks;
          s.ph  = PH_WA_HIGH;
        end
      end
      PH_R_LOW: begin
        if (expired) begin
          s.scl_dr = 1'b0;
          s.ph     = PH_R_RISE;
        end
      end
      PH_R_RISE: begin
        if (w.scl) begin
          s.shreg = {s.shreg[6:0], w.sda};
          s.dly   = c.high_ticks;
          s.ph    = PH_R_HIGH;
        end
      end
      PH_R_HIGH: begin
        if (expired) begin
          s.nbits = s.nbits + 1'b1;
          if (s.nbits >= BITS_PER_BYTE) begin
            s.rx_hold = s.shreg;
            s.scl_dr  = 1'b1;
            s.sda_dr  = !s.nack;
            s.dly     = c.low_ticks;
            s.ph      = PH_RA_LOW;
          end else begin
            s = drive_bit_in(s, c);
          end
        end
      end
      PH_RA_LOW: begin
        if (expired) begin
          s.scl_dr = 1'b0;
          s.ph     = PH_RA_RISE;
        end
      end
      PH_RA_RISE: begin
        if (w.scl) begin
          s.dly = c.high_ticks;
          s.ph  = PH_RA_HIGH;
        end
      end
      PH_WA_HIGH, PH_RA_HIGH: begin
        if (expired) begin
          s.ph   = PH_IDLE;
          s.done = 1'b1;
        end
      end
      PH_P_LOW: begin
        if (expired) begin
          s.scl_dr = 1'b0;
          s.ph     = PH_P_RISE;
        end
      end
      PH_P_RISE: begin
        if (w.scl) begin
          s.dly = c.stop_setup_ticks;
          s.ph  = PH_P_SETUP;
        end
      end
      PH_P_SETUP: begin
        if (expired) begin
          s.sda_dr = 1'b0;
          s.ph     = PH_IDLE;
          s.done   = 1'b1;
        end
      end
      default: s.ph = PH_IDLE;
    endcase
    return s;
  endfunction

  function automatic result_t bus_view(engine_t s);
    result_t r;
    r.scl_pull_low = s.scl_dr;
    r.sda_pull_low = s.sda_dr;
    r.busy_res     = (s.ph != PH_IDLE);
    r.done_res     = s.done;
    r.ack_bit      = s.ack;
    r.read_byte    = s.rx_hold;
    return r;
  endfunction

  // Line levels a well-behaved slave would present, with the odd tick of noise.
  function automatic logic [1:0] sample_lines(engine_t s);
    logic sda;
    logic scl;
    logic slave;
    if ($urandom_range(0, 19) == 0) return 2'($urandom_range(0, 3));
    scl = s.scl_dr ? 1'b0 : ($urandom_range(0, 3) != 0);
    case (s.ph)
      PH_ST_WAIT: begin
        scl   = ($urandom_range(0, 2) != 0);
        slave = ($urandom_range(0, 2) != 0);
      end
      PH_R_RISE, PH_WA_RISE: slave = 1'($urandom_range(0, 1));
      default: slave = 1'b1;
    endcase
    sda = s.sda_dr ? 1'b0 : slave;
    return {sda, scl};
  endfunction

  function automatic int pick_idle();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic check_field(input string fname, input int unsigned want, input int unsigned got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
    end
  endtask

  task automatic emit(input logic [2:0] kind, input logic [7:0] data, input logic last);
    bus_word_t  w;
    logic [1:0] lines;
    while (tick_q.size() > 200) @(posedge clk);
    lines  = sample_lines(gen_s);
    w.kind = kind;
    w.data = data;
    w.last = last;
    w.sda  = lines[1];
    w.scl  = lines[0];
    tick_q.push_back(w);
    gen_s = bus_tick(gen_s, cfg_m, w);
    n_pushed++;
    if (gaps_allowed && $urandom_range(0, 149) == 0) gaps_on = !gaps_on;
  endtask

  // Issues one command and ticks until the engine is idle again; the odd
  // command sent while busy must be ignored.
  task automatic run_op(input logic [2:0] kind, input logic [7:0] data, input logic last);
    emit(kind, data, last);
    while (gen_s.ph != PH_IDLE) begin
      if ($urandom_range(0, 9) == 0) emit(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom));
      else emit(KIND_TICK, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic settle();
    while (n_pushed != n_taken || due_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
    logic [31:0] rd;
    cfg_access(1'b1, idx, {16'h0000, val}, rd);
    case (idx)
      REG_LOW_TICKS:        cfg_m.low_ticks        = val;
      REG_HIGH_TICKS:       cfg_m.high_ticks       = val;
      REG_BUS_FREE_TICKS:   cfg_m.bus_free_ticks   = val;
      REG_START_HOLD_TICKS: cfg_m.start_hold_ticks = val;
      REG_STOP_SETUP_TICKS: cfg_m.stop_setup_ticks = val;
      default: ;
    endcase
    cfg_access(1'b0, idx, '0, rd);
    check_field("register readback", val, rd[15:0]);
  endtask

  task automatic set_timing(input logic [15:0] lo, input logic [15:0] hi, input logic [15:0] free,
                            input logic [15:0] hold, input logic [15:0] setup);
    settle();
    set_reg(REG_LOW_TICKS, lo);
    set_reg(REG_HIGH_TICKS, hi);
    set_reg(REG_BUS_FREE_TICKS, free);
    set_reg(REG_START_HOLD_TICKS, hold);
    set_reg(REG_STOP_SETUP_TICKS, setup);
  endtask

  task automatic random_transfer();
    int   n;
    logic rd;
    if ($urandom_range(0, 3) == 0) begin
      run_op(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
    end else begin
      run_op(KIND_START, 8'($urandom), 1'($urandom));
      n  = $urandom_range(1, 3);
      rd = 1'($urandom_range(0, 1));
      for (int i = 1; i <= n; i++) begin
        repeat ($urandom_range(0, 2)) emit(KIND_TICK, 8'($urandom), 1'($urandom));
        run_op(rd ? KIND_READ : KIND_WRITE, 8'($urandom),
               rd ? (i == n) : 1'($urandom_range(0, 1)));
      end
      // Now and then the transfer is left open without a stop.
      if ($urandom_range(0, 7) != 0) run_op(KIND_STOP, 8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: a new word goes out at the falling edge once the last was taken and any idle gap has run out.
  always @(negedge clk) begin : drive_p
    bus_word_t w;
    if (rst_n) begin
      if (!in_ch.valid || tick_taken) begin
        if (in_gap != 0) begin
          in_gap      <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          w = tick_q.pop_front();
          in_ch.kind      <= w.kind;
          in_ch.data_byte <= w.data;
          in_ch.last_byte <= w.last;
          in_ch.sda_in    <= w.sda;
          in_ch.scl_in    <= w.scl;
          in_ch.valid     <= 1'b1;
          in_gap          <= pick_idle();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      if (out_stall != 0) begin
        out_stall    <= out_stall - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_stall    <= pick_idle();
      end
    end
  end

  always @(posedge clk) begin : watch_p
    bus_word_t w;
    result_t   got;
    result_t   want;
    if (!rst_n) begin
      tick_taken <= 1'b0;
    end else begin
      tick_taken <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.scl_pull_low, out_ch.sda_pull_low, out_ch.busy_res, out_ch.done_res,
               out_ch.ack_bit, out_ch.read_byte};
        if (due_status_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected word, expected none, got %h", $time, got);
        end else begin
          want = due_status_q.pop_front();
          check_field("scl_pull_low", want.scl_pull_low, got.scl_pull_low);
          check_field("sda_pull_low", want.sda_pull_low, got.sda_pull_low);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("ack_bit", want.ack_bit, got.ack_bit);
          check_field("read_byte", want.read_byte, got.read_byte);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        w     = {in_ch.kind, in_ch.data_byte, in_ch.last_byte, in_ch.sda_in, in_ch.scl_in};
        chk_s = bus_tick(chk_s, cfg_m, w);
        due_status_q.push_back(bus_view(chk_s));
        n_taken <= n_taken + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_TICK;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    in_ch.sda_in    = 1'b1;
    in_ch.scl_in    = 1'b1;
    out_ch.ready    = 1'b0;
    gen_s           = '0;
    gen_s.ph        = PH_IDLE;
    chk_s           = gen_s;
    cfg_m           = '0;
    n_pushed        = 0;
    n_taken         = 0;
    n_errors        = 0;
    in_gap          = 0;
    out_stall       = 0;
    stall_cycles    = 0;
    gaps_on         = 1'b1;
    gaps_allowed    = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset timing, all zero: ignored kinds, every operation, extreme bytes.
    run_op(3'd5, 8'hFF, 1'b1);
    run_op(3'd6, 8'h00, 1'b0);
    run_op(3'd7, 8'hAA, 1'b1);
    run_op(KIND_TICK, 8'h55, 1'b0);
    run_op(KIND_START, 8'hFF, 1'b0);
    run_op(KIND_WRITE, 8'h00, 1'b1);
    run_op(KIND_WRITE, 8'hFF, 1'b0);
    run_op(KIND_READ, 8'h00, 1'b0);
    run_op(KIND_READ, 8'hFF, 1'b1);
    run_op(KIND_STOP, 8'h00, 1'b0);
    // Byte operations and a stop with no start before them; SDA stays low after the ACK.
    run_op(KIND_WRITE, 8'h5A, 1'b0);
    run_op(KIND_READ, 8'hA5, 1'b0);
    repeat (3) emit(KIND_TICK, 8'h00, 1'b0);
    run_op(KIND_STOP, 8'hFF, 1'b1);

    set_timing(16'd1, 16'd2, 16'd3, 16'd1, 16'd2);
    run_op(KIND_START, 8'hA0, 1'b0);
    run_op(KIND_READ, 8'h00, 1'b1);
    run_op(KIND_STOP, 8'h00, 1'b0);

    // Full-scale register values are only read back; the longer waits that
    // follow keep the run short, one register family at a time.
    gaps_allowed = 1'b0;
    gaps_on      = 1'b0;
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_timing(16'd0, 16'd0, 16'd12, 16'd12, 16'd12);
    run_op(KIND_START, 8'h3C, 1'b0);
    run_op(KIND_STOP, 8'h00, 1'b0);
    set_timing(16'd4, 16'd4, 16'd0, 16'd0, 16'd0);
    run_op(KIND_WRITE, 8'hC3, 1'b0);

    gaps_allowed = 1'b1;
    gaps_on      = 1'b1;
    for (int p = 0; p < 4; p++) begin
      int target;
      if (p == 0) set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      else set_timing(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                      16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                      16'($urandom_range(0, 3)));
      target = n_pushed + 40;
      while (n_pushed < target) random_transfer();
    end

    settle();
    repeat (10) @(posedge clk);
    if (n_errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
